// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge, reset included.
`define VMS_ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

// Check on every clock edge outside reset (active-low reset).
`define VMS_ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

`endif

// ===== rtl/vms_pkg.sv =====
// ----------------------------------------------------------------------------
// vms_pkg
// Types, codes and the mode/event action table of the valve motor sequencer.
// ----------------------------------------------------------------------------
package vms_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE       = 3'd0,
    MODE_UP_ACCEL   = 3'd1,
    MODE_UP_LEVEL   = 3'd2,
    MODE_DOWN_ACCEL = 3'd3,
    MODE_DOWN_LEVEL = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ACT_IGNORE    = 3'd0,
    ACT_UHS       = 3'd1,
    ACT_UL        = 3'd2,
    ACT_DHS       = 3'd3,
    ACT_DL        = 3'd4,
    ACT_STOP_UP   = 3'd5,
    ACT_STOP_DOWN = 3'd6
  } action_e;

  typedef enum logic [1:0] {
    CMD_SPEED    = 2'd0,
    CMD_MOVE     = 2'd1,
    CMD_SOLENOID = 2'd2
  } cmd_e;

  // Coil event codes; 5 to 7 mean nothing.
  localparam logic [2:0] EvNone     = 3'd0;
  localparam logic [2:0] EvUpHigh   = 3'd1;
  localparam logic [2:0] EvUpLevel  = 3'd2;
  localparam logic [2:0] EvDownHigh = 3'd3;
  localparam logic [2:0] EvDownLvl  = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CfgUpSpeeds     = 3'd0;
  localparam logic [2:0] CfgDownSpeeds   = 3'd1;
  localparam logic [2:0] CfgUpPositions  = 3'd2;
  localparam logic [2:0] CfgDownPos      = 3'd3;
  localparam logic [2:0] CfgBypassId     = 3'd4;
  localparam logic [2:0] CfgDownCheckId  = 3'd5;

  // 16-bit slots inside the packed speed and position registers.
  localparam logic [1:0] SlotAccel = 2'd0;
  localparam logic [1:0] SlotTrans = 2'd1;
  localparam logic [1:0] SlotStop  = 2'd2;

  localparam int unsigned CfgWidth = 48;
  localparam int unsigned IdWidth  = 8;

  function automatic action_e action_lookup(mode_e m, logic [2:0] ev);
    action_e a;
    a = ACT_IGNORE;
    unique case (m)
      MODE_IDLE: begin
        unique case (ev)
          EvUpHigh:   a = ACT_UHS;
          EvUpLevel:  a = ACT_UL;
          EvDownHigh: a = ACT_DHS;
          EvDownLvl:  a = ACT_DL;
          default:    a = ACT_IGNORE;
        endcase
      end
      MODE_UP_ACCEL: begin
        unique case (ev)
          EvNone, EvDownHigh, EvDownLvl: a = ACT_STOP_UP;
          EvUpLevel:                     a = ACT_UL;
          default:                       a = ACT_IGNORE;
        endcase
      end
      MODE_UP_LEVEL: begin
        unique case (ev)
          EvNone, EvDownHigh, EvDownLvl: a = ACT_STOP_UP;
          EvUpHigh:                      a = ACT_UHS;
          default:                       a = ACT_IGNORE;
        endcase
      end
      MODE_DOWN_ACCEL: begin
        unique case (ev)
          EvNone, EvUpHigh, EvUpLevel: a = ACT_STOP_DOWN;
          EvDownLvl:                   a = ACT_DL;
          default:                     a = ACT_IGNORE;
        endcase
      end
      MODE_DOWN_LEVEL: begin
        unique case (ev)
          EvNone, EvUpHigh, EvUpLevel: a = ACT_STOP_DOWN;
          EvDownHigh:                  a = ACT_DHS;
          default:                     a = ACT_IGNORE;
        endcase
      end
      default: a = ACT_IGNORE;
    endcase
    return a;
  endfunction

  function automatic mode_e action_next_mode(action_e a, mode_e cur);
    mode_e m;
    m = cur;
    unique case (a)
      ACT_UHS:                    m = MODE_UP_ACCEL;
      ACT_UL:                     m = MODE_UP_LEVEL;
      ACT_DHS:                    m = MODE_DOWN_ACCEL;
      ACT_DL:                     m = MODE_DOWN_LEVEL;
      ACT_STOP_UP, ACT_STOP_DOWN: m = MODE_IDLE;
      default:                    m = cur;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/valve_motor_sequencer_fsm_top.sv =====
// ----------------------------------------------------------------------------
// valve_motor_sequencer_fsm_top
// Five-mode valve controller: turns coil events into runs of motor commands.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake                 | Payload
//  ---------+-----------+---------------------------+-----------------------------
//  in       | input     | in_valid_i / in_ready_o   | coil_event_i
//  out      | output    | out_valid_o / out_ready_i | motor_id_o, command_o,
//           |           |                           | value_o, new_mode_o, last_o
//  cfg      | input     | cfg_we_i (no wait)        | cfg_idx_i, cfg_wdata_i
//
//  A run emits one command per cycle unless the output stalls: two for the up
//  and stop-up runs, three for the down and stop-down runs, none for an
//  ignored event. Commands pass the run register, then the output register.
//  Reset clears mode, run and output valid and loads register defaults
//  (all zero, down-check motor id 1). A stalled output holds the run; the next
//  request waits until the run's last command sits in the output register.
//
module valve_motor_sequencer_fsm_top #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  coil_event_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  motor_id_o,
  output logic [1:0]  command_o,
  output logic [15:0] value_o,
  output logic [2:0]  new_mode_o,
  output logic        last_o,

  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [47:0] cfg_wdata_i
);

  // Keep the low VALUE_WIDTH bits of a 16-bit speed or position.
  localparam int unsigned VwEff = (VALUE_WIDTH > 16) ? 16 : VALUE_WIDTH;
  localparam logic [16:0] MaskWide = (17'd1 << VwEff) - 17'd1;
  localparam logic [15:0] ValueMask = MaskWide[15:0];

  // Configuration registers.
  logic [vms_pkg::CfgWidth-1:0] up_speeds_q, down_speeds_q;
  logic [vms_pkg::CfgWidth-1:0] up_pos_q, down_pos_q;
  logic [vms_pkg::IdWidth-1:0]  bypass_id_q, down_check_id_q;

  // Mode state machine.
  vms_pkg::mode_e   mode_q, mode_d;
  vms_pkg::action_e act_in;

  // Run register: the action being emitted, one command per step.
  logic             run_valid_q, run_valid_d;
  vms_pkg::action_e run_act_q, run_act_d;
  vms_pkg::mode_e   run_mode_q, run_mode_d;
  logic [1:0]       run_step_q, run_step_d;

  // Output register.
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_motor_q;
  vms_pkg::cmd_e    out_cmd_q;
  logic [15:0]      out_value_q;
  vms_pkg::mode_e   out_mode_q;
  logic             out_last_q;

  // Current step decode.
  logic             step_down;
  vms_pkg::cmd_e    step_cmd;
  logic [1:0]       step_slot;
  logic             step_sol;
  logic             step_last;
  logic [7:0]       step_motor;
  logic [15:0]      step_value;

  logic in_fire, push, run_done;

  function automatic logic [15:0] pick_slot(logic [47:0] r, logic [1:0] s);
    logic [15:0] v;
    v = 16'd0;
    unique case (s)
      vms_pkg::SlotAccel: v = r[15:0];
      vms_pkg::SlotTrans: v = r[31:16];
      vms_pkg::SlotStop:  v = r[47:32];
      default:            v = 16'd0;
    endcase
    return v;
  endfunction

  // Advance the run into the output register whenever that register frees up.
  assign push       = run_valid_q && (!out_valid_q || out_ready_i);
  assign run_done   = push && step_last;
  assign in_ready_o = !run_valid_q || run_done;
  assign in_fire    = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Configuration writes: indexes past the list are dropped.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_speeds_q     <= '0;
      down_speeds_q   <= '0;
      up_pos_q        <= '0;
      down_pos_q      <= '0;
      bypass_id_q     <= 8'd0;
      down_check_id_q <= 8'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vms_pkg::CfgUpSpeeds:    up_speeds_q     <= cfg_wdata_i;
        vms_pkg::CfgDownSpeeds:  down_speeds_q   <= cfg_wdata_i;
        vms_pkg::CfgUpPositions: up_pos_q        <= cfg_wdata_i;
        vms_pkg::CfgDownPos:     down_pos_q      <= cfg_wdata_i;
        vms_pkg::CfgBypassId:    bypass_id_q     <= cfg_wdata_i[7:0];
        vms_pkg::CfgDownCheckId: down_check_id_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Next state: look up the action for the accepted event and move the mode.
  // Invalid events map to ignore, which keeps the mode.
  // ---------------------------------------------------------------------------
  always_comb begin
    act_in = vms_pkg::action_lookup(mode_q, coil_event_i);
    mode_d = mode_q;
    if (in_fire) begin
      mode_d = vms_pkg::action_next_mode(act_in, mode_q);
    end
  end

  // Run control: load on accept, step on each push, drop after the last.
  always_comb begin
    run_valid_d = run_valid_q;
    run_act_d   = run_act_q;
    run_mode_d  = run_mode_q;
    run_step_d  = run_step_q;
    if (in_fire) begin
      run_valid_d = (act_in != vms_pkg::ACT_IGNORE);
      run_act_d   = act_in;
      run_mode_d  = vms_pkg::action_next_mode(act_in, mode_q);
      run_step_d  = 2'd0;
    end else if (push) begin
      if (step_last) begin
        run_valid_d = 1'b0;
      end else begin
        run_step_d = run_step_q + 2'd1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Outputs: decode which command the current step of the run emits.
  // ---------------------------------------------------------------------------
  always_comb begin
    step_down = 1'b0;
    step_cmd  = vms_pkg::CMD_SPEED;
    step_slot = vms_pkg::SlotAccel;
    step_sol  = 1'b0;
    step_last = 1'b0;
    unique case (run_act_q)
      vms_pkg::ACT_UHS, vms_pkg::ACT_UL, vms_pkg::ACT_STOP_UP: begin
        step_slot = (run_act_q == vms_pkg::ACT_UHS) ? vms_pkg::SlotAccel :
                    (run_act_q == vms_pkg::ACT_UL)  ? vms_pkg::SlotTrans :
                                                      vms_pkg::SlotStop;
        step_cmd  = (run_step_q == 2'd0) ? vms_pkg::CMD_SPEED : vms_pkg::CMD_MOVE;
        step_last = (run_step_q != 2'd0);
      end
      vms_pkg::ACT_DHS, vms_pkg::ACT_DL: begin
        step_down = 1'b1;
        step_slot = (run_act_q == vms_pkg::ACT_DHS) ? vms_pkg::SlotAccel
                                                     : vms_pkg::SlotTrans;
        step_sol  = 1'b1;
        unique case (run_step_q)
          2'd0:    step_cmd = vms_pkg::CMD_SOLENOID;
          2'd1:    step_cmd = vms_pkg::CMD_SPEED;
          default: step_cmd = vms_pkg::CMD_MOVE;
        endcase
        step_last = (run_step_q == 2'd2);
      end
      vms_pkg::ACT_STOP_DOWN: begin
        // Park first, then slow down, then close the solenoid.
        step_down = 1'b1;
        step_slot = vms_pkg::SlotStop;
        step_sol  = 1'b0;
        unique case (run_step_q)
          2'd0:    step_cmd = vms_pkg::CMD_MOVE;
          2'd1:    step_cmd = vms_pkg::CMD_SPEED;
          default: step_cmd = vms_pkg::CMD_SOLENOID;
        endcase
        step_last = (run_step_q == 2'd2);
      end
      default: ;
    endcase
  end

  // Operand selection for the decoded step.
  always_comb begin
    step_motor = step_down ? down_check_id_q : bypass_id_q;
    unique case (step_cmd)
      vms_pkg::CMD_SPEED:
        step_value = pick_slot(step_down ? down_speeds_q : up_speeds_q, step_slot) & ValueMask;
      vms_pkg::CMD_MOVE:
        step_value = pick_slot(step_down ? down_pos_q : up_pos_q, step_slot) & ValueMask;
      default:
        step_value = {15'd0, step_sol};
    endcase
  end

  // Output valid: set on push, clear once taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= vms_pkg::MODE_IDLE;
      run_valid_q <= 1'b0;
      run_act_q   <= vms_pkg::ACT_IGNORE;
      run_mode_q  <= vms_pkg::MODE_IDLE;
      run_step_q  <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      run_valid_q <= run_valid_d;
      run_act_q   <= run_act_d;
      run_mode_q  <= run_mode_d;
      run_step_q  <= run_step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload: load on push only.
  always_ff @(posedge clk_i) begin
    if (push) begin
      out_motor_q <= step_motor;
      out_cmd_q   <= step_cmd;
      out_value_q <= step_value;
      out_mode_q  <= run_mode_q;
      out_last_q  <= step_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign motor_id_o  = out_motor_q;
  assign command_o   = out_cmd_q;
  assign value_o     = out_value_q;
  assign new_mode_o  = out_mode_q;
  assign last_o      = out_last_q;

endmodule

// ===== rtl/vms_checker.sv =====
// ----------------------------------------------------------------------------
// vms_checker
// Port-level checks on the valve motor sequencer's command stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vms_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  motor_id_o,
  input logic [1:0]  command_o,
  input logic [15:0] value_o,
  input logic [2:0]  new_mode_o,
  input logic        last_o
);

  `VMS_ASSERT_CLK(a_no_valid_in_reset, clk_i, !rst_ni |-> !out_valid_o)

  `VMS_ASSERT_RST(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(motor_id_o) && $stable(command_o) && $stable(value_o) && $stable(new_mode_o) && $stable(last_o))

  // A run never leaves a gap: the next command follows at once, same new mode.
  `VMS_ASSERT_RST(a_run_contiguous, clk_i, rst_ni, out_valid_o && out_ready_i && !last_o |=> out_valid_o && (new_mode_o == $past(new_mode_o)))

  `VMS_ASSERT_RST(a_solenoid_level, clk_i, rst_ni, out_valid_o && (command_o == vms_pkg::CMD_SOLENOID) |-> (value_o == 16'd0) || (value_o == 16'd1))

endmodule

bind valve_motor_sequencer_fsm_top vms_checker u_vms_checker (.*);
